// ===== hw/rtl/fim_pkg.sv =====
// ----------------------------------------------------------------------------
// fim_pkg: shared types and constants for the frame interval monitor
// Request codes, field widths, register map and the sequencer state type.
// ----------------------------------------------------------------------------
package fim_pkg;

    localparam int TIME_W   = 32;
    localparam int EXP_W    = 16;
    localparam int REQ_W    = 2;
    localparam int CNT_W    = 32;
    localparam int OUT_W    = 4 * CNT_W + 1;
    localparam int OUT_TD_W = ((OUT_W + 7) / 8) * 8;
    localparam int ADDR_W   = 3;
    localparam int DIV_CNT_W = $clog2(TIME_W);

    localparam logic [EXP_W-1:0]  EXPECTED_RESET = EXP_W'(50);
    localparam logic [ADDR_W-1:0] ADDR_EXPECTED  = ADDR_W'(0);

    localparam logic [REQ_W-1:0] REQ_ARRIVAL = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LATE    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_JIT,
        ST_DIV,
        ST_RESP
    } fim_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } fim_div_stat_t;

endpackage

// ===== hw/rtl/fim_regs.sv =====
// ----------------------------------------------------------------------------
// fim_regs: configuration register block
// APB-style slave holding the expected frame interval.
// ----------------------------------------------------------------------------
module fim_regs
    import fim_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [EXP_W-1:0]  expected
);

    logic [EXP_W-1:0] expected_reg;
    logic [EXP_W-1:0] expected_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        expected_next = expected_reg;
        if (wr_en && (paddr == ADDR_EXPECTED))
        begin
            expected_next = pwdata[EXP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg <= EXPECTED_RESET;
        end
        else
        begin
            expected_reg <= expected_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_EXPECTED)
        begin
            prdata = {{(32-EXP_W){1'b0}}, expected_reg};
        end
    end

    assign expected = expected_reg;

endmodule

// ===== hw/rtl/fim_div.sv =====
// ----------------------------------------------------------------------------
// fim_div: iterative restoring divider
// 32-bit dividend by 16-bit divisor, one quotient bit per cycle through a
// single shared subtract-and-compare unit.
// ----------------------------------------------------------------------------
module fim_div
    import fim_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TIME_W-1:0] dividend,
    input  logic [EXP_W-1:0]  divisor,
    output logic [TIME_W-1:0] quotient,
    output fim_div_stat_t     stat
);

    logic [TIME_W-1:0]    q_reg;
    logic [TIME_W-1:0]    q_next;
    logic [EXP_W-1:0]     rem_reg;
    logic [EXP_W-1:0]     rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [EXP_W:0]       rem_shift;
    logic [EXP_W:0]       trial;
    logic                 fits;

    // Shared unit: shift in the next dividend bit, trial-subtract the divisor
    assign rem_shift = {rem_reg, q_reg[TIME_W-1]};
    assign fits      = rem_shift >= {1'b0, divisor};
    assign trial     = rem_shift - {1'b0, divisor};

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[TIME_W-2:0], fits};
            rem_next = fits ? trial[EXP_W-1:0] : rem_shift[EXP_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(TIME_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign quotient  = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== hw/rtl/frame_interval_monitor_top.sv =====
// ----------------------------------------------------------------------------
// frame_interval_monitor_top: frame arrival interval and jitter monitor
// Tracks intervals, peak jitter, missed and total frame counts; answers
// late queries and clears statistics on request.
//
//  channel  | dir | signals                       | content
//  ---------+-----+-------------------------------+------------------------------
//  s_*      | in  | s_tvalid s_tready s_tdata     | tdata now_ms, tuser req_type
//           |     | s_tuser                       |
//  m_*      | out | m_tvalid m_tready m_tdata     | interval, jitter, missed,
//           |     |                               | frame count, late
//  apb      | in  | psel penable pwrite paddr     | expected_interval at 0x0
//           |     | pwdata prdata pready          |
//
//  A frame arrival that needs a missed-frame estimate passes from transfer to
//  result through two setup states (calc, jitter), one divider iteration per
//  quotient bit, a step to collect the quotient and the load of the output
//  register. Other requests go from calc (and jitter for an arrival) straight
//  to the output load. s_tready is high only when the sequencer is idle. A
//  result waiting on m_tready does not block the next input transfer; it
//  stalls only the final load of the next result. Reset clears all statistics.
// ----------------------------------------------------------------------------
module frame_interval_monitor_top
    import fim_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // APB configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // Request stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [TIME_W-1:0]   s_tdata,   // [31:0] now_ms
    input  logic [REQ_W-1:0]    s_tuser,   // [1:0] req_type
    // Result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_TD_W-1:0] m_tdata    // [31:0] frame_gap, [63:32] max_jitter_ms,
                                           // [95:64] missed_total, [127:96] frame_total,
                                           // [128] late, rest zero
);

    fim_state_t        state_reg;
    fim_state_t        state_next;

    logic [EXP_W-1:0]  expected;
    logic [EXP_W:0]    expected_x2;

    logic [REQ_W-1:0]  req_reg;
    logic [REQ_W-1:0]  req_next;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] now_next;
    logic [TIME_W-1:0] iv_reg;
    logic [TIME_W-1:0] iv_next;
    logic [TIME_W-1:0] last_arrival_reg;
    logic [TIME_W-1:0] last_arrival_next;
    logic [TIME_W-1:0] last_interval_reg;
    logic [TIME_W-1:0] last_interval_next;
    logic [CNT_W-1:0]  peak_reg;
    logic [CNT_W-1:0]  peak_next;
    logic [CNT_W-1:0]  missed_reg;
    logic [CNT_W-1:0]  missed_next;
    logic [CNT_W-1:0]  frame_reg;
    logic [CNT_W-1:0]  frame_next;
    logic              late_reg;
    logic              late_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [OUT_W-1:0]  out_data_reg;
    logic [OUT_W-1:0]  out_data_next;

    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] dev;
    logic              div_start;
    logic [TIME_W-1:0] quotient;
    fim_div_stat_t     div_stat;

    fim_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .expected (expected)
    );

    fim_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (iv_reg),
        .divisor  (expected),
        .quotient (quotient),
        .stat     (div_stat)
    );

    assign expected_x2 = {expected, 1'b0};
    assign elapsed     = now_reg - last_arrival_reg;
    assign dev         = (iv_reg >= {{(TIME_W-EXP_W){1'b0}}, expected})
                       ? (iv_reg - {{(TIME_W-EXP_W){1'b0}}, expected})
                       : ({{(TIME_W-EXP_W){1'b0}}, expected} - iv_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        req_next           = req_reg;
        now_next           = now_reg;
        iv_next            = iv_reg;
        last_arrival_next  = last_arrival_reg;
        last_interval_next = last_interval_reg;
        peak_next          = peak_reg;
        missed_next        = missed_reg;
        frame_next         = frame_reg;
        late_next          = late_reg;
        out_data_next      = out_data_reg;
        out_valid_next     = out_valid_reg;
        s_tready           = 1'b0;
        div_start          = 1'b0;

        // Drop the held result once it is taken
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    req_next   = s_tuser;
                    now_next   = s_tdata;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                iv_next   = elapsed;
                late_next = 1'b0;
                state_next = ST_RESP;
                case (req_reg)
                    REQ_ARRIVAL:
                    begin
                        if (last_arrival_reg != '0)
                        begin
                            state_next = ST_JIT;
                        end
                        else
                        begin
                            last_arrival_next = now_reg;
                            frame_next        = frame_reg + 1'b1;
                        end
                    end
                    REQ_LATE:
                    begin
                        late_next = (last_arrival_reg != '0) &&
                                    (elapsed > {{(TIME_W-EXP_W-1){1'b0}}, expected_x2});
                    end
                    REQ_CLEAR:
                    begin
                        peak_next         = '0;
                        missed_next       = '0;
                        frame_next        = '0;
                        last_arrival_next = '0;
                    end
                    default:
                    begin
                        late_next = 1'b0;
                    end
                endcase
            end
            ST_JIT:
            begin
                last_interval_next = iv_reg;
                last_arrival_next  = now_reg;
                frame_next         = frame_reg + 1'b1;
                if (dev > peak_reg)
                begin
                    peak_next = dev;
                end
                if ((expected != '0) &&
                    (iv_reg > {{(TIME_W-EXP_W-1){1'b0}}, expected_x2}))
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    missed_next = missed_reg + quotient - 1'b1;
                    state_next  = ST_RESP;
                end
            end
            ST_RESP:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_data_next  = {late_reg, frame_reg, missed_reg, peak_reg,
                                      last_interval_reg};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_arrival_reg  <= '0;
            last_interval_reg <= '0;
            peak_reg          <= '0;
            missed_reg        <= '0;
            frame_reg         <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            last_arrival_reg  <= last_arrival_next;
            last_interval_reg <= last_interval_next;
            peak_reg          <= peak_next;
            missed_reg        <= missed_next;
            frame_reg         <= frame_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        now_reg      <= now_next;
        iv_reg       <= iv_next;
        late_reg     <= late_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TD_W-OUT_W){1'b0}}, out_data_reg};

    // One request in flight: a transfer closes the input until the result is loaded
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a request is in flight");

    a_div_collect: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DIV) && div_stat.done) |=> (state_reg == ST_RESP))
        else $error("quotient not collected");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_DIV) |-> !div_stat.done)
        else $error("divider finished outside the divide state");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_CALC) && (req_reg == REQ_CLEAR))
        |=> ((last_arrival_reg == '0) && (frame_reg == '0) && (missed_reg == '0)))
        else $error("clear left statistics behind");

endmodule
